// ----- rtl/core/tid_pkg.sv -----
package tid_pkg;

    // Largest row count that one block may hold
    localparam int MAX_ROWS = 65536;

    localparam int ROW_W = 16;
    localparam int THR_W = 32;
    localparam int SAMPLE_W = 16;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W = 8;

    // Row counter stops here: min(MAX_ROWS - 1, all ones in ROW_W bits)
    localparam logic [ROW_W-1:0] ROW_LIMIT =
        (MAX_ROWS - 1 > (1 << ROW_W) - 1) ? {ROW_W{1'b1}} : ROW_W'(MAX_ROWS - 1);

    // Trigger modes
    localparam logic [MODE_W-1:0] MODE_RAISE_FALL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAISE_RAISE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EQUAL       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOT_EQUAL   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 8'd1;

    typedef struct packed {
        logic             active;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] start;
    } t_gate_state;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] first_row;
        logic [ROW_W-1:0] last_row;
        logic             open_at_end;
    } t_result;

endpackage

// ----- rtl/core/trigger_interval_detector_top.sv -----
// Trigger interval detector. Each input item is one row: s_axis_tdata[15:0] carries the
// unsigned sample and s_axis_tlast marks the last row of a data block. The sample is
// compared with the signed threshold; trigger_mode chooses how the gate opens and
// closes. A closing row yields an item with the interval from the opening row up to the
// row before it (tuser 0); a block that ends while the gate is open yields the interval
// up to that last row (tuser 1), and the gate stays open into the next block, which
// counts from row 0. Rows past the counter limit reuse the limit index. The block takes
// one row per cycle while the output is not stalled: a two-stage path (input register,
// then result register) with the combinational gate decision between them. Config
// writes (index 0 trigger_mode, 1 threshold) are always taken and belong to idle times.
module trigger_interval_detector_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input rows
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] sample
    input  logic                              s_axis_tlast,   // block_end
    // intervals
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [15:0] first_row, [31:16] last_row
    output logic                              m_axis_tuser,   // open_at_end
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tid_pkg::THR_W-1:0]         i_cfg_data
);
    import tid_pkg::*;

    logic [MODE_W-1:0]   r_mode;
    logic [THR_W-1:0]    r_threshold;
    t_gate_state         r_state;
    t_gate_state         n_state;
    t_result             n_result;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_in_last;

    logic                r_out_valid;
    logic [ROW_W-1:0]    r_out_first;
    logic [ROW_W-1:0]    r_out_last;
    logic                r_out_open;

    logic                out_free;
    logic                advance;

    // Output slot is free when empty or being taken this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign o_cfg_ready   = 1'b1;

    // Store configuration registers, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RAISE_FALL;
            r_threshold <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TRIGGER_MODE) begin
                r_mode <= i_cfg_data[MODE_W-1:0];
            end else if (i_cfg_index == CFG_THRESHOLD) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    // Capture input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
            r_in_last   <= s_axis_tlast;
        end
    end

    tid_eval u_eval (
        .i_state     (r_state),
        .i_mode      (r_mode),
        .i_threshold (r_threshold),
        .i_sample    (r_in_sample),
        .i_block_end (r_in_last),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // Advance gate state once per processed row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.valid) begin
            r_out_first <= n_result.first_row;
            r_out_last  <= n_result.last_row;
            r_out_open  <= n_result.open_at_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_last, r_out_first};
    assign m_axis_tuser  = r_out_open;

`ifndef NO_ASSERTIONS
    a_row_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.row <= ROW_LIMIT)
        else $error("row counter beyond limit");

    a_block_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_state.row == '0 && r_state.start == '0)
        else $error("block end did not restart row count");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.valid && !n_result.open_at_end |=> !r_state.active)
        else $error("gate still active after close");

    a_open_end_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.valid && n_result.open_at_end |=> r_state.active)
        else $error("open interval reported with gate closed");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipeline stalled");
`endif

endmodule

// ----- rtl/core/tid_eval.sv -----
module tid_eval (
    input  tid_pkg::t_gate_state                 i_state,
    input  logic [tid_pkg::MODE_W-1:0]           i_mode,
    input  logic [tid_pkg::THR_W-1:0]            i_threshold,
    input  logic [tid_pkg::SAMPLE_W-1:0]         i_sample,
    input  logic                                 i_block_end,
    output tid_pkg::t_gate_state                 o_state,
    output tid_pkg::t_result                     o_result
);
    import tid_pkg::*;

    logic signed [THR_W:0] sample_s;
    logic signed [THR_W:0] thr_s;
    logic                  gt;
    logic                  eq;
    logic                  lt;
    logic                  open_hit;
    logic                  close_hit;
    logic                  active_mid;
    logic [ROW_W-1:0]      start_mid;

    // Compare the unsigned sample with the signed level on a common signed width
    assign sample_s = $signed({{(THR_W + 1 - SAMPLE_W){1'b0}}, i_sample});
    assign thr_s    = $signed({i_threshold[THR_W-1], i_threshold});
    assign gt = sample_s > thr_s;
    assign eq = sample_s == thr_s;
    assign lt = sample_s < thr_s;

    // Pick the open and close conditions for the mode
    always_comb begin
        unique case (i_mode)
            MODE_RAISE_FALL: begin
                open_hit  = gt;
                close_hit = lt;
            end
            MODE_RAISE_RAISE: begin
                open_hit  = gt;
                close_hit = gt;
            end
            MODE_EQUAL: begin
                open_hit  = eq;
                close_hit = !eq;
            end
            default: begin
                open_hit  = !eq;
                close_hit = eq;
            end
        endcase
    end

    // One decision per row: open when idle, close when active, then handle block end
    always_comb begin
        o_result             = '0;
        active_mid           = i_state.active;
        start_mid            = i_state.start;
        o_result.first_row   = i_state.start;
        o_result.last_row    = i_state.row - ROW_W'(1);
        if (!i_state.active) begin
            if (open_hit) begin
                active_mid = 1'b1;
                start_mid  = i_state.row;
            end
        end else if (close_hit) begin
            o_result.valid = 1'b1;
            active_mid     = 1'b0;
        end

        o_state.active = active_mid;
        if (i_block_end) begin
            if (active_mid) begin
                o_result.valid       = 1'b1;
                o_result.first_row   = start_mid;
                o_result.last_row    = i_state.row;
                o_result.open_at_end = 1'b1;
            end
            o_state.row   = '0;
            o_state.start = '0;
        end else begin
            o_state.start = start_mid;
            o_state.row   = (i_state.row < ROW_LIMIT) ? i_state.row + ROW_W'(1) : i_state.row;
        end
    end

endmodule
